// ===== hdl/mbpe_pkg.sv =====
package mbpe_pkg;

  // Pixels covered by one bitmap data byte, most significant bit leftmost.
  localparam int unsigned PIX_PER_BYTE = 8;

  // Depth of the job queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Item kinds carried on the input tuser.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_DATA  = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PEN_COLOR  = 2'd0,
    CFG_BG_COLOR   = 2'd1,
    CFG_BG_FILL    = 2'd2
  } cfg_reg_e;

endpackage

// ===== hdl/mbpe_queue.sv =====
module mbpe_queue #(
  parameter int unsigned WIDTH = 41,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             ready_o,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign ready_o = (count_q != CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset; entries are read only once written.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/mbpe_front.sv =====
module mbpe_front #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned JOB_W      = 2 * 12 + 17
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  mode_i,
  input  logic [COORD_BITS-1:0] origin_x_i,
  input  logic [COORD_BITS-1:0] origin_y_i,
  input  logic [COORD_BITS-1:0] box_width_i,
  input  logic [COORD_BITS-1:0] box_height_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  bg_fill_i,
  output logic                  job_valid_o,
  input  logic                  job_ready_i,
  output logic [JOB_W-1:0]      job_o
);

  localparam int unsigned NPIX = mbpe_pkg::PIX_PER_BYTE;
  localparam int unsigned XW   = COORD_BITS + 2;
  localparam int unsigned LW   = COORD_BITS + 1;

  // Box state: cursors are kept unwrapped, limits one bit wider than coordinates.
  logic                  active_q, active_d;
  logic [XW-1:0]         cur_x_q, cur_x_d;
  logic [LW-1:0]         cur_y_q, cur_y_d;
  logic [COORD_BITS-1:0] left_q, left_d;
  logic [LW-1:0]         rlim_q, rlim_d;
  logic [LW-1:0]         blim_q, blim_d;

  logic                  accept;
  logic [XW-1:0]         span;
  logic [XW-1:0]         next_x;
  logic [LW-1:0]         next_y;
  logic [NPIX-1:0]       in_box;
  logic [NPIX-1:0]       bit_set;
  logic [NPIX-1:0]       mask;
  logic                  final_byte;
  logic                  row_end;

  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the byte: which pixels fall inside the box and which get written.
  assign span       = {1'b0, rlim_q} - cur_x_q;
  assign next_x     = cur_x_q + XW'(NPIX);
  assign next_y     = cur_y_q + LW'(1);
  assign row_end    = (next_x >= {1'b0, rlim_q});
  assign final_byte = row_end && (next_y >= blim_q);

  always_comb begin
    for (int i = 0; i < NPIX; i++) begin
      in_box[i]  = (span > XW'(i));
      bit_set[i] = data_byte_i[NPIX-1-i];
    end
  end

  assign mask = in_box & (bit_set | {NPIX{bg_fill_i}});

  // Only data bytes inside an active box that write something become jobs.
  assign job_valid_o = accept && (mode_i == mbpe_pkg::MODE_DATA) && active_q && (mask != '0);
  assign job_o = {final_byte, cur_y_q[COORD_BITS-1:0], cur_x_q[COORD_BITS-1:0], bit_set, mask};

  // Box setup on start items, cursor advance on data bytes.
  always_comb begin
    active_d = active_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    left_d   = left_q;
    rlim_d   = rlim_q;
    blim_d   = blim_q;
    if (accept) begin
      if (mode_i == mbpe_pkg::MODE_START) begin
        left_d   = origin_x_i;
        cur_x_d  = XW'(origin_x_i);
        cur_y_d  = LW'(origin_y_i);
        rlim_d   = {1'b0, origin_x_i} + {1'b0, box_width_i};
        blim_d   = {1'b0, origin_y_i} + {1'b0, box_height_i};
        active_d = (box_width_i != '0) && (box_height_i != '0);
      end else if (active_q) begin
        if (row_end) begin
          cur_x_d = XW'(left_q);
          cur_y_d = next_y;
          if (next_y >= blim_q) begin
            active_d = 1'b0;
          end
        end else begin
          cur_x_d = next_x;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      left_q   <= '0;
      rlim_q   <= '0;
      blim_q   <= '0;
    end else begin
      active_q <= active_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      left_q   <= left_d;
      rlim_q   <= rlim_d;
      blim_q   <= blim_d;
    end
  end

  // An open box always has its cursor inside the box.
  a_cursor_x_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (cur_x_q < {1'b0, rlim_q}))
    else $error("cursor column outside an active box");

  a_cursor_y_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (cur_y_q < blim_q))
    else $error("cursor row outside an active box");

  // The first pixel of a byte is always inside the box.
  a_first_pixel_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> in_box[0])
    else $error("leftmost pixel of a byte clipped in an active box");

endmodule

// ===== hdl/mbpe_back.sv =====
module mbpe_back #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned COLOR_BITS = 16,
  parameter int unsigned JOB_W      = 2 * 12 + 17
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  output logic                  job_pop_o,
  input  logic [JOB_W-1:0]      job_i,
  input  logic [COLOR_BITS-1:0] pen_color_i,
  input  logic [COLOR_BITS-1:0] bg_color_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic [COLOR_BITS-1:0] pixel_color_o,
  output logic                  last_of_byte_o,
  output logic                  box_done_o
);

  localparam int unsigned NPIX  = mbpe_pkg::PIX_PER_BYTE;
  localparam int unsigned IDX_W = $clog2(NPIX);

  // Job being expanded: remaining pixel mask, bit values and position.
  logic [NPIX-1:0]       mask_q, mask_d;
  logic [NPIX-1:0]       set_q;
  logic [COORD_BITS-1:0] x_q;
  logic [COORD_BITS-1:0] y_q;
  logic                  done_q;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] out_x_q;
  logic [COORD_BITS-1:0] out_y_q;
  logic [COLOR_BITS-1:0] out_color_q;
  logic                  out_last_q;
  logic                  out_done_q;

  logic                  advance;
  logic [IDX_W-1:0]      idx;
  logic [NPIX-1:0]       rem_mask;
  logic                  pop;

  // Leftmost pixel still to write.
  always_comb begin
    idx = '0;
    for (int i = NPIX - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

  assign rem_mask = mask_q & ~(NPIX'(1) << idx);
  assign advance  = (!out_valid_q || out_ready_i) && (mask_q != '0);
  assign pop      = job_valid_i && ((mask_q == '0) || (advance && (rem_mask == '0)));

  assign job_pop_o = pop;

  always_comb begin
    mask_d = mask_q;
    if (pop) begin
      mask_d = job_i[NPIX-1:0];
    end else if (advance) begin
      mask_d = rem_mask;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Job payload is loaded on a pop.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      set_q  <= job_i[2*NPIX-1:NPIX];
      x_q    <= job_i[2*NPIX+COORD_BITS-1:2*NPIX];
      y_q    <= job_i[2*NPIX+2*COORD_BITS-1:2*NPIX+COORD_BITS];
      done_q <= job_i[2*NPIX+2*COORD_BITS];
    end
  end

  // One pixel transfer per cycle into the output register while the receiver is not stalling it.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_x_q     <= x_q + COORD_BITS'(idx);
      out_y_q     <= y_q;
      out_color_q <= set_q[idx] ? pen_color_i : bg_color_i;
      out_last_q  <= (rem_mask == '0);
      out_done_q  <= done_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = out_x_q;
  assign pixel_y_o      = out_y_q;
  assign pixel_color_o  = out_color_q;
  assign last_of_byte_o = out_last_q;
  assign box_done_o     = out_done_q;

  // A loaded job always has a pixel to write.
  a_job_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (mask_q != '0))
    else $error("empty job loaded into the back end");

  // Emitting a pixel always leaves a valid result in the output register.
  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("pixel emitted without a valid output");

  // A new job is taken only once the current one has no pixels left after this cycle.
  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> ((mask_q == '0) || ($countones(mask_q) == 1 && advance)))
    else $error("job loaded while pixels of the current one remain");

endmodule

// ===== hdl/mono_bitmap_pixel_expander_top.sv =====
// Monochrome bitmap pixel expander.
// Input stream (s_axis_*): tuser carries the item kind, 0 opens a box, 1 is a
// bitmap data byte. tdata carries origin, size and the data byte. Each data
// byte inside an open box expands into its pixel writes, leftmost first.
// Output stream (m_axis_*): one transfer per pixel write; tlast marks the last
// write of a byte and tuser marks every write of the final byte of the box.
// Configuration channel (cfg_*): pen color, background color and fill mode,
// always ready; write it only while no pixels are pending.
// Throughput: one input item per cycle while the two-entry job queue has
// room; a data byte then occupies the back end until its pixel writes (one
// to eight) are out, and the pixel output rate is one per cycle while tready is high.
// Start items, bytes outside a box and bytes that write nothing never reach
// the back end.
// The first pixel of a byte passes the job queue, the back end and its output register.
// Reset clears the box state, the queue and the output register; the colors
// return to pen 0 and background all ones, fill mode off.
// A stalled receiver holds the output register; the back end and then the
// queue fill, after which s_axis_tready_o drops.
module mono_bitmap_pixel_expander_top #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned COLOR_BITS = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // Input items.
  input  logic                                        s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // Fields from bit 0 up: origin_x, origin_y, box_width, box_height, data_byte.
  input  logic [(4*COORD_BITS+8+7)/8*8-1:0]           s_axis_tdata_i,
  // Field: mode.
  input  logic                                        s_axis_tuser_i,
  // Pixel writes.
  output logic                                        m_axis_tvalid_o,
  input  logic                                        m_axis_tready_i,
  // Fields from bit 0 up: pixel_x, pixel_y, pixel_color.
  output logic [(2*COORD_BITS+COLOR_BITS+7)/8*8-1:0]  m_axis_tdata_o,
  // Field: last_of_byte.
  output logic                                        m_axis_tlast_o,
  // Field: box_done.
  output logic                                        m_axis_tuser_o,
  // Configuration writes.
  input  logic                                        cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  logic [mbpe_pkg::CFG_IDX_BITS-1:0]           cfg_index_i,
  input  logic [COLOR_BITS-1:0]                       cfg_data_i
);

  localparam int unsigned OUT_BITS   = 2 * COORD_BITS + COLOR_BITS;
  localparam int unsigned OUT_DATA_W = (OUT_BITS + 7) / 8 * 8;
  localparam int unsigned JOB_W      = 2 * COORD_BITS + 2 * mbpe_pkg::PIX_PER_BYTE + 1;

  logic [COLOR_BITS-1:0] pen_color_q;
  logic [COLOR_BITS-1:0] bg_color_q;
  logic                  bg_fill_q;

  logic                  front_valid;
  logic [JOB_W-1:0]      front_job;
  logic                  queue_ready;
  logic                  queue_valid;
  logic [JOB_W-1:0]      queue_job;
  logic                  back_pop;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [COLOR_BITS-1:0] pixel_color;

  // Configuration registers; writes to unused indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_color_q <= '0;
      bg_color_q  <= COLOR_BITS'(32'h0000_FFFF);
      bg_fill_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mbpe_pkg::CFG_PEN_COLOR: pen_color_q <= cfg_data_i;
        mbpe_pkg::CFG_BG_COLOR:  bg_color_q  <= cfg_data_i;
        mbpe_pkg::CFG_BG_FILL:   bg_fill_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  mbpe_front #(
    .COORD_BITS (COORD_BITS),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .mode_i       (s_axis_tuser_i),
    .origin_x_i   (s_axis_tdata_i[COORD_BITS-1:0]),
    .origin_y_i   (s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS]),
    .box_width_i  (s_axis_tdata_i[3*COORD_BITS-1:2*COORD_BITS]),
    .box_height_i (s_axis_tdata_i[4*COORD_BITS-1:3*COORD_BITS]),
    .data_byte_i  (s_axis_tdata_i[4*COORD_BITS+7:4*COORD_BITS]),
    .bg_fill_i    (bg_fill_q),
    .job_valid_o  (front_valid),
    .job_ready_i  (queue_ready),
    .job_o        (front_job)
  );

  mbpe_queue #(
    .WIDTH (JOB_W),
    .DEPTH (mbpe_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .ready_o (queue_ready),
    .data_i  (front_job),
    .valid_o (queue_valid),
    .pop_i   (back_pop),
    .data_o  (queue_job)
  );

  mbpe_back #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS),
    .JOB_W      (JOB_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (queue_valid),
    .job_pop_o      (back_pop),
    .job_i          (queue_job),
    .pen_color_i    (pen_color_q),
    .bg_color_i     (bg_color_q),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .pixel_x_o      (pixel_x),
    .pixel_y_o      (pixel_y),
    .pixel_color_o  (pixel_color),
    .last_of_byte_o (m_axis_tlast_o),
    .box_done_o     (m_axis_tuser_o)
  );

  // Pack the pixel fields, zero filled to whole bytes.
  assign m_axis_tdata_o = OUT_DATA_W'({pixel_color, pixel_y, pixel_x});

endmodule

// ===== sim/mbpe_pixel_monitor.sv =====
module mbpe_pixel_monitor #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned COLOR_BITS = 16,
  parameter int unsigned IN_W       = 56,
  parameter int unsigned OUT_W      = 40
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Item channel.
  input  logic                              in_tvalid_i,
  input  logic                              in_tready_i,
  input  logic [IN_W-1:0]                   in_tdata_i,
  input  logic                              in_tuser_i,
  // Pixel channel.
  input  logic                              out_tvalid_i,
  input  logic                              out_tready_i,
  input  logic [OUT_W-1:0]                  out_tdata_i,
  input  logic                              out_tlast_i,
  input  logic                              out_tuser_i,
  // Register writes.
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [mbpe_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COLOR_BITS-1:0]             cfg_data_i,
  // Pixels still due and mismatches seen so far.
  output int unsigned                       pending_o,
  output int unsigned                       mismatch_count_o
);

  // Width of the unwrapped cursors and limits.
  localparam int unsigned CW = COORD_BITS + 2;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
    logic                  done;
  } pixel_t;

  // Color registers as the block should hold them.
  logic [COLOR_BITS-1:0] pen_q  = '0;
  logic [COLOR_BITS-1:0] bg_q   = COLOR_BITS'(32'h0000_FFFF);
  logic                  fill_q = 1'b0;

  // Box state. Cursors and limits are kept wide so that they never wrap.
  logic                  box_open   = 1'b0;
  logic [CW-1:0]         cur_x      = '0;
  logic [CW-1:0]         cur_y      = '0;
  logic [COORD_BITS-1:0] left_q     = '0;
  logic [CW-1:0]         right_lim  = '0;
  logic [CW-1:0]         bottom_lim = '0;

  int unsigned pending_cnt  = 0;
  int unsigned mismatch_cnt = 0;

  pixel_t pixels_due[$];

  assign pending_o        = pending_cnt;
  assign mismatch_count_o = mismatch_cnt;

  task automatic report_mismatch(input string msg);
    $display("%0t: pixel mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic apply_reg(input logic [mbpe_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [COLOR_BITS-1:0] value);
    case (idx)
      mbpe_pkg::CFG_PEN_COLOR: pen_q = value;
      mbpe_pkg::CFG_BG_COLOR:  bg_q = value;
      mbpe_pkg::CFG_BG_FILL:   fill_q = value[0];
      default: ;
    endcase
  endtask

  // Updates the box state for one item and queues the pixels of a data byte.
  task automatic expand_item(input logic kind, input logic [IN_W-1:0] word);
    logic [COORD_BITS-1:0] ox;
    logic [COORD_BITS-1:0] oy;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
    logic [7:0]            bits;
    logic [CW-1:0]         px;
    logic                  at_end;
    logic                  set;
    pixel_t                burst[mbpe_pkg::PIX_PER_BYTE];
    int                    n;
    int                    i;
    ox   = word[0 +: COORD_BITS];
    oy   = word[COORD_BITS +: COORD_BITS];
    w    = word[2*COORD_BITS +: COORD_BITS];
    h    = word[3*COORD_BITS +: COORD_BITS];
    bits = word[4*COORD_BITS +: 8];
    if (kind == mbpe_pkg::MODE_START) begin
      left_q     = ox;
      cur_x      = CW'(ox);
      cur_y      = CW'(oy);
      right_lim  = CW'(ox) + CW'(w);
      bottom_lim = CW'(oy) + CW'(h);
      box_open   = (w != '0) && (h != '0);
    end else if (box_open) begin
      at_end = (cur_x + CW'(mbpe_pkg::PIX_PER_BYTE) >= right_lim) &&
               (cur_y + CW'(1) >= bottom_lim);
      n = 0;
      for (i = 0; i < mbpe_pkg::PIX_PER_BYTE; i++) begin
        px  = cur_x + CW'(i);
        set = bits[mbpe_pkg::PIX_PER_BYTE-1-i];
        // Pixels past the right edge of the box are clipped.
        if (px >= right_lim) break;
        if (set || fill_q) begin
          burst[n].x     = px[COORD_BITS-1:0];
          burst[n].y     = cur_y[COORD_BITS-1:0];
          burst[n].color = set ? pen_q : bg_q;
          burst[n].last  = 1'b0;
          burst[n].done  = at_end;
          n++;
        end
      end
      if (n > 0) begin
        burst[n-1].last = 1'b1;
      end
      for (i = 0; i < n; i++) begin
        pixels_due.push_back(burst[i]);
      end
      // Advance to the next byte, wrapping to the next row at the edge.
      cur_x = cur_x + CW'(mbpe_pkg::PIX_PER_BYTE);
      if (cur_x >= right_lim) begin
        cur_x = CW'(left_q);
        cur_y = cur_y + CW'(1);
        if (cur_y >= bottom_lim) begin
          box_open = 1'b0;
        end
      end
    end
  endtask

  task automatic check_pixel(input logic [OUT_W-1:0] word, input logic last,
                             input logic done);
    pixel_t                want;
    logic [COORD_BITS-1:0] got_x;
    logic [COORD_BITS-1:0] got_y;
    logic [COLOR_BITS-1:0] got_color;
    got_x     = word[0 +: COORD_BITS];
    got_y     = word[COORD_BITS +: COORD_BITS];
    got_color = word[2*COORD_BITS +: COLOR_BITS];
    if (pixels_due.size() == 0) begin
      report_mismatch($sformatf("unexpected write x=%0d y=%0d color=%h",
                                got_x, got_y, got_color));
      return;
    end
    want = pixels_due.pop_front();
    if (got_x !== want.x) begin
      report_mismatch($sformatf("x %0d, want %0d", got_x, want.x));
    end
    if (got_y !== want.y) begin
      report_mismatch($sformatf("y %0d, want %0d", got_y, want.y));
    end
    if (got_color !== want.color) begin
      report_mismatch($sformatf("color %h, want %h at x=%0d y=%0d",
                                got_color, want.color, want.x, want.y));
    end
    if (last !== want.last) begin
      report_mismatch($sformatf("last-of-byte %b, want %b at x=%0d y=%0d",
                                last, want.last, want.x, want.y));
    end
    if (done !== want.done) begin
      report_mismatch($sformatf("box-done %b, want %b at x=%0d y=%0d",
                                done, want.done, want.x, want.y));
    end
  endtask

  // Each edge: register writes first, then the item, then the pixel transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q      = '0;
      bg_q       = COLOR_BITS'(32'h0000_FFFF);
      fill_q     = 1'b0;
      box_open   = 1'b0;
      cur_x      = '0;
      cur_y      = '0;
      left_q     = '0;
      right_lim  = '0;
      bottom_lim = '0;
      pixels_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        apply_reg(cfg_index_i, cfg_data_i);
      end
      if (in_tvalid_i && in_tready_i) begin
        expand_item(in_tuser_i, in_tdata_i);
      end
      if (out_tvalid_i && out_tready_i) begin
        check_pixel(out_tdata_i, out_tlast_i, out_tuser_i);
      end
    end
    pending_cnt = pixels_due.size();
  end

endmodule

// ===== sim/tb_mono_bitmap_pixel_expander_top.sv =====
module tb_mono_bitmap_pixel_expander_top;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned COLOR_BITS = 16;
  localparam int unsigned IN_W       = ((4*COORD_BITS + 8 + 7) / 8) * 8;
  localparam int unsigned OUT_W      = ((2*COORD_BITS + COLOR_BITS + 7) / 8) * 8;
  localparam int unsigned COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam int unsigned COLOR_MAX  = (1 << COLOR_BITS) - 1;
  // Cycles allowed after the last pixel before the block counts as idle.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS_PER_PHASE = 95;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              s_axis_tvalid_i = 1'b0;
  logic                              s_axis_tready_o;
  logic [IN_W-1:0]                   s_axis_tdata_i = '0;
  logic                              s_axis_tuser_i = mbpe_pkg::MODE_START;
  logic                              m_axis_tvalid_o;
  logic                              m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]                  m_axis_tdata_o;
  logic                              m_axis_tlast_o;
  logic                              m_axis_tuser_o;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [mbpe_pkg::CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [COLOR_BITS-1:0]             cfg_data_i = '0;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned src_idle_pct = 8;
  int unsigned rx_idle_pct = 75;
  logic        rx_hold_req = 1'b0;

  always #1 clk_i = ~clk_i;

  mono_bitmap_pixel_expander_top #(
    .COORD_BITS(COORD_BITS),
    .COLOR_BITS(COLOR_BITS)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tlast_o,
    .m_axis_tuser_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  mbpe_pixel_monitor #(
    .COORD_BITS(COORD_BITS),
    .COLOR_BITS(COLOR_BITS),
    .IN_W(IN_W),
    .OUT_W(OUT_W)
  ) pixel_monitor (
    .clk_i,
    .rst_ni,
    .in_tvalid_i(s_axis_tvalid_i),
    .in_tready_i(s_axis_tready_o),
    .in_tdata_i(s_axis_tdata_i),
    .in_tuser_i(s_axis_tuser_i),
    .out_tvalid_i(m_axis_tvalid_o),
    .out_tready_i(m_axis_tready_i),
    .out_tdata_i(m_axis_tdata_o),
    .out_tlast_i(m_axis_tlast_o),
    .out_tuser_i(m_axis_tuser_o),
    .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .pending_o(pending),
    .mismatch_count_o(mismatches)
  );

  // Pixel receiver: random stalls, or one long hold-off when requested.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [IN_W-1:0] pack_item(input int unsigned ox, input int unsigned oy,
                                                input int unsigned w, input int unsigned h,
                                                input int unsigned b);
    logic [IN_W-1:0] word;
    word = '0;
    word[0 +: COORD_BITS]            = ox[COORD_BITS-1:0];
    word[COORD_BITS +: COORD_BITS]   = oy[COORD_BITS-1:0];
    word[2*COORD_BITS +: COORD_BITS] = w[COORD_BITS-1:0];
    word[3*COORD_BITS +: COORD_BITS] = h[COORD_BITS-1:0];
    word[4*COORD_BITS +: 8]          = b[7:0];
    return word;
  endfunction

  // Offers one item after a random gap and returns once it is transferred.
  // Valid stays high for a following item unless a gap is inserted.
  task automatic push_item(input logic kind, input logic [IN_W-1:0] word);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= word;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // The unused fields of each item carry random values.
  task automatic start_box(input int unsigned ox, input int unsigned oy,
                           input int unsigned w, input int unsigned h);
    push_item(mbpe_pkg::MODE_START, pack_item(ox, oy, w, h, $urandom_range(255)));
  endtask

  task automatic send_byte(input int unsigned b);
    push_item(mbpe_pkg::MODE_DATA,
              pack_item($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                        $urandom_range(COORD_MAX), $urandom_range(COORD_MAX), b));
  endtask

  // Stops offering items and waits until every due pixel has arrived.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all three configuration registers back to back; call only when settled.
  task automatic load_colors(input int unsigned pen, input int unsigned bg,
                             input int unsigned fill);
    mbpe_pkg::cfg_reg_e regs[3];
    int unsigned        vals[3];
    int                 i;
    regs = '{mbpe_pkg::CFG_PEN_COLOR, mbpe_pkg::CFG_BG_COLOR, mbpe_pkg::CFG_BG_FILL};
    vals = '{pen, bg, fill & 1};
    for (i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i][COLOR_BITS-1:0];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int unsigned pick_byte();
    if ($urandom_range(4) == 0) begin
      return $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return $urandom_range(255);
  endfunction

  // Mostly complete boxes with random content; some are cut short by the
  // next start, some huge ones only get a few bytes, and stray bytes follow.
  task automatic random_boxes(input int unsigned target);
    int unsigned sent;
    int unsigned roll;
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned cut;
    int unsigned i;
    sent = 0;
    while (sent < target) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        w = $urandom_range(COORD_MAX, 1);
        h = $urandom_range(COORD_MAX, 1);
      end else begin
        w = $urandom_range(40, 1);
        h = $urandom_range(4, 1);
      end
      start_box($urandom_range(COORD_MAX), $urandom_range(COORD_MAX), w, h);
      sent++;
      total = ((w + 7) / 8) * h;
      if (total > 24) begin
        cut = $urandom_range(24, 1);
      end else if ($urandom_range(9) == 0) begin
        cut = $urandom_range(total, 0);
      end else begin
        cut = total;
      end
      for (i = 0; i < cut; i++) begin
        send_byte(pick_byte());
      end
      sent += cut;
      // Bytes after a finished box are ignored by the block.
      if (cut == total && $urandom_range(4) == 0) begin
        repeat ($urandom_range(2, 1)) send_byte(pick_byte());
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed, reset colors: transparent mode with pen 0.
    send_byte(8'hFF);                 // no box open yet
    start_box(10, 20, 0, 5);          // empty box
    send_byte(8'hFF);
    start_box(COORD_MAX - 5, COORD_MAX - 1, 12, 3);  // wraps in x and y
    send_byte(8'hFF);
    send_byte(8'h0F);                 // every set bit falls past the edge
    send_byte(8'h00);                 // nothing to write
    send_byte(8'hF0);
    send_byte(8'hA5);
    send_byte(8'h81);                 // last byte of the box, right bit clipped
    send_byte(8'hFF);                 // box already finished
    settle();

    // Directed, fill mode with extreme colors.
    load_colors(COLOR_MAX, 0, 1);
    start_box(0, 0, 1, 1);
    send_byte(8'h7F);
    start_box(COORD_MAX, COORD_MAX, 16, 2);
    send_byte(8'h55);
    start_box(100, 200, COORD_MAX, COORD_MAX);  // abandons the running box
    send_byte(8'h00);
    send_byte(8'hFF);
    start_box(5, 6, 8, 1);
    send_byte(8'hAA);
    settle();

    // Receiver holds off while a full box of fill-mode bytes is offered.
    load_colors($urandom_range(COLOR_MAX), $urandom_range(COLOR_MAX), 1);
    rx_hold_req = 1'b1;
    start_box($urandom_range(COORD_MAX), $urandom_range(COORD_MAX), 64, 4);
    repeat (32) send_byte($urandom_range(255));
    settle();

    // Random phases with different stall patterns.
    load_colors($urandom_range(COLOR_MAX), $urandom_range(COLOR_MAX), 0);
    random_boxes(RANDOM_ITEMS_PER_PHASE);
    settle();

    src_idle_pct = 75;
    rx_idle_pct  = 8;
    load_colors($urandom_range(COLOR_MAX), $urandom_range(COLOR_MAX), 1);
    random_boxes(RANDOM_ITEMS_PER_PHASE);
    settle();

    src_idle_pct = 0;
    rx_idle_pct  = 0;
    load_colors(0, COLOR_MAX, $urandom_range(1));
    random_boxes(RANDOM_ITEMS_PER_PHASE);
    settle();
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
